// File: sv/scale_space_extremum_detector_macros.svh
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
// The assertion is disabled while the active-low reset is asserted.
`ifndef SCALE_SPACE_EXTREMUM_DETECTOR_MACROS_SVH
`define SCALE_SPACE_EXTREMUM_DETECTOR_MACROS_SVH

// Same-cycle property.
`define SSED_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent now, consequent on the next edge.
`define SSED_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/ssed_pkg.sv
// ----------------------------------------------------------------------------
// ssed_pkg
// Shared types and constants for the scale-space extremum detector.
// ----------------------------------------------------------------------------
package ssed_pkg;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 15;

	localparam int THR_BITS      = 15;
	localparam int BORDER_BITS   = 6;
	localparam int WIDTH_BITS    = 11;
	localparam int HEIGHT_BITS   = 12;
	localparam int ROW_BITS      = 12;
	localparam int COL_OUT_BITS  = 10;

	localparam int NUM_LAYERS    = 3;
	localparam int WIN_TAPS      = 9;
	localparam int CENTRE_LAYER  = 1;
	localparam int CENTRE_TAP    = 4;

	localparam int OUT_DEPTH     = 4;
	localparam int OUT_PTR_BITS  = 2;
	localparam int OUT_CNT_BITS  = 3;
	localparam int OUT_OCC_BITS  = 4;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CONTRAST = 2'd0,
		REG_BORDER   = 2'd1,
		REG_WIDTH    = 2'd2,
		REG_HEIGHT   = 2'd3
	} cfg_reg_t;

	localparam logic [THR_BITS-1:0]    RST_CONTRAST = 15'd128;
	localparam logic [BORDER_BITS-1:0] RST_BORDER   = 6'd5;
	localparam logic [WIDTH_BITS-1:0]  RST_WIDTH    = 11'd640;
	localparam logic [HEIGHT_BITS-1:0] RST_HEIGHT   = 12'd480;

	// per-layer outcome of the neighbour compare
	typedef struct packed {
		logic ge;
		logic le;
	} lane_flags_t;

	// centre attributes judged beside the lanes
	typedef struct packed {
		logic                    valid;
		logic                    in_border;
		logic                    over_thr;
		logic                    pos;
		logic                    neg;
		logic [ROW_BITS-1:0]     row;
		logic [COL_OUT_BITS-1:0] col;
	} centre_info_t;

	typedef struct packed {
		logic                    window_valid;
		logic                    is_extremum;
		logic                    is_minimum;
		logic [ROW_BITS-1:0]     centre_row;
		logic [COL_OUT_BITS-1:0] centre_col;
	} result_t;

endpackage

// File: sv/ssed_pixel_if.sv
// ----------------------------------------------------------------------------
// ssed_pixel_if
// Pixel request channel: three co-located DoG samples and a frame marker.
// ----------------------------------------------------------------------------
interface ssed_pixel_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_below;
	logic signed [SAMPLE_BITS-1:0] sample_middle;
	logic signed [SAMPLE_BITS-1:0] sample_above;
	logic                          frame_start;

	modport source (output valid, sample_below, sample_middle, sample_above, frame_start,
		input ready);
	modport sink (input valid, sample_below, sample_middle, sample_above, frame_start,
		output ready);
endinterface

// File: sv/ssed_result_if.sv
// ----------------------------------------------------------------------------
// ssed_result_if
// Result request channel: window status, extremum flags and centre position.
// ----------------------------------------------------------------------------
interface ssed_result_if;
	import ssed_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    window_valid;
	logic                    is_extremum;
	logic                    is_minimum;
	logic [ROW_BITS-1:0]     centre_row;
	logic [COL_OUT_BITS-1:0] centre_col;

	modport source (output valid, window_valid, is_extremum, is_minimum, centre_row,
		centre_col, input ready);
	modport sink (input valid, window_valid, is_extremum, is_minimum, centre_row,
		centre_col, output ready);
endinterface

// File: sv/ssed_cfg_if.sv
// ----------------------------------------------------------------------------
// ssed_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ssed_cfg_if;
	import ssed_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/ssed_ram.sv
// ----------------------------------------------------------------------------
// ssed_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssed_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/ssed_lane.sv
// ----------------------------------------------------------------------------
// ssed_lane
// One scale layer: compares the centre against the nine window taps.
// ----------------------------------------------------------------------------
module ssed_lane #(
	parameter int SAMPLE_BITS = 16,
	parameter int TAPS        = 9
) (
	input  logic                          clk,
	input  logic signed [SAMPLE_BITS-1:0] centre,
	input  logic signed [SAMPLE_BITS-1:0] taps [TAPS],
	output ssed_pkg::lane_flags_t         flags_s3
);
	import ssed_pkg::*;

	lane_flags_t flags;

	// the centre tap of the middle layer compares equal, so no exclusion needed
	always_comb begin
		flags.ge = 1'b1;
		flags.le = 1'b1;
		for (int k = 0; k < TAPS; k++) begin
			if (centre < taps[k]) flags.ge = 1'b0;
			if (centre > taps[k]) flags.le = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		flags_s3 <= flags;
	end

endmodule

// File: sv/ssed_merge.sv
// ----------------------------------------------------------------------------
// ssed_merge
// Combines the lane flags with the centre checks into one result.
// ----------------------------------------------------------------------------
module ssed_merge (
	input  ssed_pkg::lane_flags_t  lanes [ssed_pkg::NUM_LAYERS],
	input  ssed_pkg::centre_info_t info,
	output ssed_pkg::result_t      res
);
	import ssed_pkg::*;

	logic all_ge;
	logic all_le;
	logic gate;

	always_comb begin
		all_ge = 1'b1;
		all_le = 1'b1;
		for (int l = 0; l < NUM_LAYERS; l++) begin
			all_ge = all_ge & lanes[l].ge;
			all_le = all_le & lanes[l].le;
		end
		gate = info.valid & info.in_border & info.over_thr;

		res.window_valid = info.valid;
		res.is_extremum  = gate & ((info.pos & all_ge) | (info.neg & all_le));
		res.is_minimum   = gate & info.neg & all_le;
		res.centre_row   = info.valid ? info.row : '0;
		res.centre_col   = info.valid ? info.col : '0;
	end

endmodule

// File: sv/scale_space_extremum_detector.sv
// ----------------------------------------------------------------------------
// scale_space_extremum_detector: 3x3x3 DoG extremum test, three compare lanes
// A result is offered from the output queue after its pixel passes stages 1 to 3.
// Throughput: one pixel per cycle while pixel ready is high; set by the line-store RAM read per pixel.
// Reset: line-store clear sweep over all MAX_WIDTH addresses, pixel ready low meanwhile.
// ----------------------------------------------------------------------------
module scale_space_extremum_detector #(
	parameter int MAX_WIDTH   = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	ssed_pixel_if.sink   pixel,
	ssed_result_if.source result,
	ssed_cfg_if.sink     cfg
);
	import ssed_pkg::*;

	localparam int SB        = SAMPLE_BITS;
	localparam int ADDR_BITS = $clog2(MAX_WIDTH);
	localparam int CNT_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int WCMP_BITS = (CNT_BITS > WIDTH_BITS) ? CNT_BITS : WIDTH_BITS;
	localparam int XB        = ((ADDR_BITS > BORDER_BITS) ? ADDR_BITS : BORDER_BITS) + 1;
	localparam int MAG_BITS  = ((SB + 1) > THR_BITS) ? (SB + 1) : THR_BITS;
	localparam int RAM_W     = NUM_LAYERS * 2 * SB;
	localparam logic [WCMP_BITS-1:0] MAXW      = WCMP_BITS'(MAX_WIDTH);
	localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(MAX_WIDTH - 1);

	// configuration
	logic [THR_BITS-1:0]    thr_q;
	logic [BORDER_BITS-1:0] border_q;
	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;

	// raster position and clear sweep
	logic [CNT_BITS-1:0]    col_q;
	logic [HEIGHT_BITS-1:0] row_q;
	logic                   clr_q;
	logic [ADDR_BITS-1:0]   clr_addr_q;

	logic [WCMP_BITS-1:0]   width_ext;
	logic [CNT_BITS-1:0]    eff_w;
	logic [HEIGHT_BITS-1:0] eff_h;
	logic [CNT_BITS-1:0]    c_pre;
	logic [CNT_BITS-1:0]    c_cur;
	logic [HEIGHT_BITS-1:0] r_pre;
	logic [HEIGHT_BITS:0]   r_inc;
	logic [HEIGHT_BITS-1:0] r_cur;
	logic [CNT_BITS-1:0]    c_nxt;
	logic [CNT_BITS-1:0]    c_adv;
	logic [HEIGHT_BITS:0]   r_adv;
	logic [HEIGHT_BITS-1:0] r_nxt;
	logic [ADDR_BITS-1:0]   col_idx;
	logic                   accept;

	// stage 1
	logic                   v_s1;
	logic [ADDR_BITS-1:0]   col_s1;
	logic [ROW_BITS-1:0]    row_s1;
	logic signed [SB-1:0]   samp_s1 [NUM_LAYERS];
	logic                   fwd_s1;
	logic [RAM_W-1:0]       fwd_data_s1;
	logic [RAM_W-1:0]       ram_rdata;
	logic [RAM_W-1:0]       rd_word;
	logic [RAM_W-1:0]       wr_word;
	logic signed [SB-1:0]   top [NUM_LAYERS];
	logic signed [SB-1:0]   mid [NUM_LAYERS];
	logic                   ram_we;
	logic [ADDR_BITS-1:0]   ram_waddr;
	logic [RAM_W-1:0]       ram_wdata;

	logic signed [SB-1:0]   win_q [NUM_LAYERS][WIN_TAPS];

	// stage 2
	logic                   v_s2;
	logic [ADDR_BITS-1:0]   col_s2;
	logic [ROW_BITS-1:0]    row_s2;
	logic [ROW_BITS-1:0]    cr;
	logic [ADDR_BITS-1:0]   cc;
	logic signed [SB-1:0]   centre;
	logic [SB:0]            mag;
	centre_info_t           info;

	// stage 3
	logic                   v_s3;
	centre_info_t           info_s3;
	lane_flags_t            lanes_s3 [NUM_LAYERS];
	result_t                merged;

	// output queue
	result_t                fifo_q [OUT_DEPTH];
	logic [OUT_PTR_BITS-1:0] wr_ptr_q;
	logic [OUT_PTR_BITS-1:0] rd_ptr_q;
	logic [OUT_CNT_BITS-1:0] cnt_q;
	logic [OUT_OCC_BITS-1:0] occ;
	logic                    pop;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= RST_CONTRAST;
			border_q <= RST_BORDER;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_CONTRAST: thr_q    <= cfg.data[THR_BITS-1:0];
				REG_BORDER:   border_q <= cfg.data[BORDER_BITS-1:0];
				REG_WIDTH:    width_q  <= cfg.data[WIDTH_BITS-1:0];
				REG_HEIGHT:   height_q <= cfg.data[HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_ext = WCMP_BITS'(width_q);
		if (width_q == '0) begin
			eff_w = CNT_BITS'(1);
		end else if (width_ext > MAXW) begin
			eff_w = CNT_BITS'(MAX_WIDTH);
		end else begin
			eff_w = CNT_BITS'(width_ext);
		end
		eff_h = (height_q == '0) ? HEIGHT_BITS'(1) : height_q;
	end

	// ---------------- raster position ----------------
	// position is wrapped on entry, so a register change between frames is absorbed
	always_comb begin
		c_pre = pixel.frame_start ? '0 : col_q;
		r_pre = pixel.frame_start ? '0 : row_q;
		if (c_pre >= eff_w) begin
			c_cur = '0;
			r_inc = {1'b0, r_pre} + (HEIGHT_BITS + 1)'(1);
		end else begin
			c_cur = c_pre;
			r_inc = {1'b0, r_pre};
		end
		r_cur   = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[HEIGHT_BITS-1:0];
		col_idx = c_cur[ADDR_BITS-1:0];

		// advance, wrapping with the sizes in force for this pixel
		c_nxt = c_cur + CNT_BITS'(1);
		if (c_nxt >= eff_w) begin
			c_adv = '0;
			r_adv = {1'b0, r_cur} + (HEIGHT_BITS + 1)'(1);
		end else begin
			c_adv = c_nxt;
			r_adv = {1'b0, r_cur};
		end
		r_nxt = (r_adv >= {1'b0, eff_h}) ? '0 : r_adv[HEIGHT_BITS-1:0];
	end

	// in-flight items plus queued results must fit the queue
	assign pop         = result.valid & result.ready;
	assign occ         = OUT_OCC_BITS'(v_s1) + OUT_OCC_BITS'(v_s2) + OUT_OCC_BITS'(v_s3)
		+ OUT_OCC_BITS'(cnt_q) - OUT_OCC_BITS'(pop);
	assign pixel.ready = ~clr_q & (occ < OUT_OCC_BITS'(OUT_DEPTH));
	assign accept      = pixel.valid & pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (accept) begin
				col_q <= c_adv;
				row_q <= r_nxt;
			end
			if (clr_q) begin
				if (clr_addr_q == LAST_ADDR) begin
					clr_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
				end
			end
		end
	end

	// ---------------- stage 1: line stores and windows ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= accept;
			// same column written this cycle: the RAM read returned the old word
			fwd_s1 <= accept & v_s1 & (col_idx == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1     <= col_idx;
			row_s1     <= r_cur;
			samp_s1[0] <= pixel.sample_below;
			samp_s1[1] <= pixel.sample_middle;
			samp_s1[2] <= pixel.sample_above;
		end
		fwd_data_s1 <= wr_word;
	end

	assign rd_word = fwd_s1 ? fwd_data_s1 : ram_rdata;

	// RAM word per layer: {row two back, row one back}
	always_comb begin
		for (int l = 0; l < NUM_LAYERS; l++) begin
			top[l] = rd_word[l*2*SB + SB +: SB];
			mid[l] = rd_word[l*2*SB +: SB];
			wr_word[l*2*SB + SB +: SB] = mid[l];
			wr_word[l*2*SB +: SB]      = samp_s1[l];
		end
	end

	assign ram_we    = clr_q | v_s1;
	assign ram_waddr = clr_q ? clr_addr_q : col_s1;
	assign ram_wdata = clr_q ? '0 : wr_word;

	ssed_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (col_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int l = 0; l < NUM_LAYERS; l++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[l][r*3]     <= win_q[l][r*3 + 1];
					win_q[l][r*3 + 1] <= win_q[l][r*3 + 2];
				end
				win_q[l][2] <= top[l];
				win_q[l][5] <= mid[l];
				win_q[l][8] <= samp_s1[l];
			end
		end
	end

	// ---------------- stage 2: lanes and centre checks ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			col_s2 <= col_s1;
			row_s2 <= row_s1;
		end
	end

	assign centre = win_q[CENTRE_LAYER][CENTRE_TAP];

	genvar g;
	generate
		for (g = 0; g < NUM_LAYERS; g++) begin : g_lane
			ssed_lane #(
				.SAMPLE_BITS (SB),
				.TAPS        (WIN_TAPS)
			) u_lane (
				.clk      (clk),
				.centre   (centre),
				.taps     (win_q[g]),
				.flags_s3 (lanes_s3[g])
			);
		end
	endgenerate

	always_comb begin
		cr  = row_s2 - ROW_BITS'(1);
		cc  = col_s2 - ADDR_BITS'(1);
		// magnitude of the most negative sample still fits one extra bit
		mag = centre[SB-1] ? ((SB + 1)'(0) - {centre[SB-1], centre}) : {1'b0, centre};

		info.valid     = (row_s2 >= ROW_BITS'(2)) & (col_s2 >= ADDR_BITS'(2));
		info.in_border = ({1'b0, cr} >= (ROW_BITS + 1)'(border_q))
			& (({1'b0, cr} + (ROW_BITS + 1)'(border_q)) < {1'b0, eff_h})
			& (XB'(cc) >= XB'(border_q))
			& ((XB'(cc) + XB'(border_q)) < XB'(eff_w));
		info.over_thr  = MAG_BITS'(mag) > MAG_BITS'(thr_q);
		info.pos       = ~centre[SB-1] & (centre != '0);
		info.neg       = centre[SB-1];
		info.row       = cr;
		info.col       = COL_OUT_BITS'(cc);
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			info_s3 <= info;
		end
	end

	// ---------------- stage 3: merge into the output queue ----------------
	ssed_merge u_merge (
		.lanes (lanes_s3),
		.info  (info_s3),
		.res   (merged)
	);

	always_ff @(posedge clk) begin
		if (v_s3) begin
			fifo_q[wr_ptr_q] <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s3) wr_ptr_q <= wr_ptr_q + OUT_PTR_BITS'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + OUT_PTR_BITS'(1);
			cnt_q <= cnt_q + OUT_CNT_BITS'(v_s3) - OUT_CNT_BITS'(pop);
		end
	end

	assign result.valid        = (cnt_q != '0);
	assign result.window_valid = fifo_q[rd_ptr_q].window_valid;
	assign result.is_extremum  = fifo_q[rd_ptr_q].is_extremum;
	assign result.is_minimum   = fifo_q[rd_ptr_q].is_minimum;
	assign result.centre_row   = fifo_q[rd_ptr_q].centre_row;
	assign result.centre_col   = fifo_q[rd_ptr_q].centre_col;

endmodule

// File: sv/ssed_checker.sv
// ----------------------------------------------------------------------------
// ssed_checker
// Port-level checks for the extremum detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "scale_space_extremum_detector_macros.svh"

module ssed_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              pixel_valid,
	input logic                              pixel_ready,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic                              window_valid,
	input logic                              is_extremum,
	input logic                              is_minimum,
	input logic [ssed_pkg::ROW_BITS-1:0]     centre_row,
	input logic [ssed_pkg::COL_OUT_BITS-1:0] centre_col
);
	import ssed_pkg::*;

	logic                    in_acc;
	logic                    out_acc;
	logic [OUT_OCC_BITS-1:0] outstanding_q;

	assign in_acc  = pixel_valid & pixel_ready;
	assign out_acc = result_valid & result_ready;

	// requests taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + OUT_OCC_BITS'(in_acc) - OUT_OCC_BITS'(out_acc);
		end
	end

	`SSED_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid, "result withdrawn while stalled")
	`SSED_ASSERT(a_no_orphan, clk, arst_n, result_valid |-> outstanding_q != '0, "result without a pending pixel")
	`SSED_ASSERT(a_blank_result, clk, arst_n, result_valid && !window_valid |-> !is_extremum && !is_minimum && centre_row == '0 && centre_col == '0, "incomplete window result not blank")
	`SSED_ASSERT(a_min_is_ext, clk, arst_n, result_valid && is_minimum |-> is_extremum, "minimum flagged without extremum")

endmodule

bind scale_space_extremum_detector ssed_checker u_ssed_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel.valid),
	.pixel_ready  (pixel.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.window_valid (result.window_valid),
	.is_extremum  (result.is_extremum),
	.is_minimum   (result.is_minimum),
	.centre_row   (result.centre_row),
	.centre_col   (result.centre_col)
);
